### design/tbea_pkg.sv
// ----------------------------------------------------------------------------
// tbea_pkg: shared types and constants
// Item layouts, command and result codes, and sizes for the token-bucket admitter.
// ----------------------------------------------------------------------------
package tbea_pkg;

	localparam int unsigned QUEUE_DEPTH  = 16;
	localparam int unsigned QW           = $clog2(QUEUE_DEPTH);
	localparam int unsigned FW           = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned MAX_RATE_HZ  = 10000;
	localparam int unsigned RATE_W       = $clog2(MAX_RATE_HZ + 1);
	localparam int unsigned USEC_PER_SEC = 1000000;
	localparam int unsigned COST_W       = 20;
	localparam int unsigned CREDIT_W     = 30;
	localparam int unsigned CREDIT_LIMIT = 900000000;

	typedef enum logic [2:0] {
		CMD_TICK    = 3'd0,
		CMD_SUBMIT  = 3'd1,
		CMD_PAUSE   = 3'd2,
		CMD_UNPAUSE = 3'd3,
		CMD_CLEAR   = 3'd4,
		CMD_CANCEL  = 3'd5,
		CMD_STOP    = 3'd6,
		CMD_NONE    = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		KIND_ADMIT   = 3'd0,
		KIND_QUEUED  = 3'd1,
		KIND_STOPPED = 3'd2,
		KIND_FULL    = 3'd3,
		KIND_NONE    = 3'd4
	} kind_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [7:0]  event_id;
		logic [31:0] elapsed_us;
	} in_t;

	typedef struct packed {
		logic [2:0]          kind;
		logic [7:0]          tag_out;
		logic [4:0]          queued_count;
		logic [CREDIT_W-1:0] credit_now;
		logic                last;
	} out_t;

	// decoded command from the front part
	typedef struct packed {
		cmd_t        op;
		logic [7:0]  id;
		logic [31:0] elapsed;
	} op_t;

	// rate unit status toward the back part
	typedef struct packed {
		logic                busy;
		logic                done;
		logic [COST_W-1:0]   cost;
		logic [CREDIT_W-1:0] cap;
	} rate_t;

	localparam int unsigned ADDR_EPS   = 0;
	localparam int unsigned ADDR_BURST = 1;

endpackage

### design/tbea_front.sv
// ----------------------------------------------------------------------------
// tbea_front: command intake
// Accepts items, decodes the command and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module tbea_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  tbea_pkg::in_t  in_item,
	output logic           op_valid,
	output tbea_pkg::op_t  op,
	input  logic           op_take
);

	tbea_pkg::op_t slot_q [2];
	logic          rd_q;
	logic          wr_q;
	logic [1:0]    cnt_q;
	tbea_pkg::op_t dec;
	logic          do_push;
	logic          do_pop;

	// decode command code
	always_comb begin
		dec.id      = in_item.event_id;
		dec.elapsed = in_item.elapsed_us;
		case (in_item.cmd)
			3'd0: dec.op = tbea_pkg::CMD_TICK;
			3'd1: dec.op = tbea_pkg::CMD_SUBMIT;
			3'd2: dec.op = tbea_pkg::CMD_PAUSE;
			3'd3: dec.op = tbea_pkg::CMD_UNPAUSE;
			3'd4: dec.op = tbea_pkg::CMD_CLEAR;
			3'd5: dec.op = tbea_pkg::CMD_CANCEL;
			3'd6: dec.op = tbea_pkg::CMD_STOP;
			default: dec.op = tbea_pkg::CMD_NONE;
		endcase
	end

	assign full     = (cnt_q == 2'd2);
	assign op_valid = (cnt_q != 2'd0);
	assign op       = slot_q[rd_q];
	assign do_push  = push && !full;
	assign do_pop   = op_take && op_valid;

	// queue storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= dec;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (do_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

`ifndef ASSERT_OFF
	a_no_take_empty: assert property (@(posedge clk) disable iff (!arst_n)
		op_take |-> op_valid) else $error("take from empty command queue");
`endif

endmodule

### design/tbea_rate.sv
// ----------------------------------------------------------------------------
// tbea_rate: rate registers and cost/cap computation
// Holds the two registers; after a write, divides one second by the clamped
// rate one bit a cycle, then multiplies by the burst size and caps the result.
// ----------------------------------------------------------------------------
module tbea_rate (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  logic            wr_idx,
	input  logic [15:0]     wr_data,
	output logic [15:0]     eps,
	output logic [15:0]     burst,
	output tbea_pkg::rate_t rate
);

	typedef enum logic [1:0] {R_IDLE, R_DIV, R_MUL, R_CAP} rstate_t;

	rstate_t                          st_q;
	logic [15:0]                      eps_q;
	logic [15:0]                      burst_q;
	logic [tbea_pkg::RATE_W-1:0]      div_q;
	logic [tbea_pkg::RATE_W-1:0]      rem_q;
	logic [tbea_pkg::COST_W-1:0]      quo_q;
	logic [4:0]                       bit_q;
	logic [tbea_pkg::COST_W+15:0]     prod_q;
	logic [tbea_pkg::COST_W-1:0]      cost_q;
	logic [tbea_pkg::CREDIT_W-1:0]    cap_q;
	logic                             done_q;
	logic [15:0]                      new_eps;
	logic [tbea_pkg::RATE_W-1:0]      clamp;
	logic [tbea_pkg::RATE_W:0]        trial;
	logic                             fits;

	assign new_eps = (wr_en && !wr_idx) ? wr_data : eps_q;

	// clamp rate to 1..MAX_RATE_HZ
	always_comb begin
		if (new_eps > 16'(tbea_pkg::MAX_RATE_HZ)) begin
			clamp = tbea_pkg::RATE_W'(tbea_pkg::MAX_RATE_HZ);
		end else if (new_eps == 16'd0) begin
			clamp = tbea_pkg::RATE_W'(1);
		end else begin
			clamp = new_eps[tbea_pkg::RATE_W-1:0];
		end
	end

	// one restoring division step
	assign trial = {rem_q, quo_q[tbea_pkg::COST_W-1]};
	assign fits  = (trial >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= R_IDLE;
			eps_q   <= 16'd1;
			burst_q <= 16'd1;
			cost_q  <= tbea_pkg::COST_W'(tbea_pkg::USEC_PER_SEC);
			cap_q   <= tbea_pkg::CREDIT_W'(tbea_pkg::USEC_PER_SEC);
			done_q  <= 1'b0;
			div_q   <= '0;
			rem_q   <= '0;
			quo_q   <= '0;
			bit_q   <= '0;
			prod_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (wr_en) begin
				if (wr_idx) burst_q <= wr_data;
				else eps_q <= wr_data;
				div_q <= clamp;
				rem_q <= '0;
				quo_q <= tbea_pkg::COST_W'(tbea_pkg::USEC_PER_SEC);
				bit_q <= 5'(tbea_pkg::COST_W - 1);
				st_q  <= R_DIV;
			end else begin
				case (st_q)
					R_DIV: begin
						rem_q <= fits ? tbea_pkg::RATE_W'(trial - {1'b0, div_q})
						              : trial[tbea_pkg::RATE_W-1:0];
						quo_q <= {quo_q[tbea_pkg::COST_W-2:0], fits};
						bit_q <= bit_q - 5'd1;
						if (bit_q == 5'd0) st_q <= R_MUL;
					end
					R_MUL: begin
						cost_q <= quo_q;
						prod_q <= quo_q * burst_q;
						st_q   <= R_CAP;
					end
					R_CAP: begin
						if (prod_q > (tbea_pkg::COST_W+16)'(tbea_pkg::CREDIT_LIMIT)) begin
							cap_q <= tbea_pkg::CREDIT_W'(tbea_pkg::CREDIT_LIMIT);
						end else begin
							cap_q <= prod_q[tbea_pkg::CREDIT_W-1:0];
						end
						done_q <= 1'b1;
						st_q   <= R_IDLE;
					end
					default: st_q <= R_IDLE;
				endcase
			end
		end
	end

	assign eps        = eps_q;
	assign burst      = burst_q;
	assign rate.busy  = (st_q != R_IDLE) || wr_en || done_q;
	assign rate.done  = done_q;
	assign rate.cost  = cost_q;
	assign rate.cap   = cap_q;

`ifndef ASSERT_OFF
	a_done_after_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == R_CAP && !wr_en) |=> done_q) else $error("cap step without done");
	a_cost_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> cost_q != '0) else $error("zero unit cost");
`endif

endmodule

### design/tbea_back.sv
// ----------------------------------------------------------------------------
// tbea_back: command execution
// Keeps credit and the event queue, runs drain, stop and cancel walks one entry
// a cycle when not stalled, and writes results to a two-entry result queue.
// ----------------------------------------------------------------------------
module tbea_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            op_valid,
	input  tbea_pkg::op_t   op,
	output logic            op_take,
	input  tbea_pkg::rate_t rate,
	output logic            empty,
	input  logic            pop,
	output tbea_pkg::out_t  res_item
);

	typedef enum logic [2:0] {S_IDLE, S_DRAIN, S_STOP, S_CANCEL, S_FIN} state_t;

	state_t                        st_q;
	logic [tbea_pkg::CREDIT_W-1:0] credit_q;
	logic                          paused_q;
	logic                          stopped_q;
	logic [tbea_pkg::QW-1:0]       head_q;
	logic [tbea_pkg::FW-1:0]       fill_q;
	logic [tbea_pkg::QW-1:0]       ptr_q;
	logic [tbea_pkg::FW-1:0]       k_q;
	logic [7:0]                    id_q;
	logic [7:0]                    tag_mem [tbea_pkg::QUEUE_DEPTH];
	logic                          live_mem [tbea_pkg::QUEUE_DEPTH];
	tbea_pkg::out_t                pend_q;
	logic                          pend_v_q;
	tbea_pkg::out_t                rq_q [2];
	logic                          rq_rd_q;
	logic                          rq_wr_q;
	logic [1:0]                    rq_cnt_q;

	logic                          rq_full;
	logic                          rq_push;
	tbea_pkg::out_t                rq_data;
	logic                          go;
	logic [tbea_pkg::CREDIT_W:0]   cost_w;
	logic                          afford;
	logic [tbea_pkg::QW-1:0]       tail;
	logic [tbea_pkg::CREDIT_W+2:0] sum;
	logic                          mem_wr;
	logic [tbea_pkg::QW-1:0]       mem_addr;
	logic                          mem_live;
	logic [7:0]                    head_tag;
	logic                          head_live;
	logic                          ptr_live;
	logic [7:0]                    ptr_tag;

	assign rq_full   = (rq_cnt_q == 2'd2);
	assign go        = !rq_full && !rate.busy;
	assign cost_w    = {{(tbea_pkg::CREDIT_W+1-tbea_pkg::COST_W){1'b0}}, rate.cost};
	assign afford    = ({1'b0, credit_q} >= cost_w);
	assign tail      = head_q + fill_q[tbea_pkg::QW-1:0];
	assign sum       = {3'b0, credit_q} + {1'b0, op.elapsed};
	assign head_tag  = tag_mem[head_q];
	assign head_live = live_mem[head_q];
	assign ptr_tag   = tag_mem[ptr_q];
	assign ptr_live  = live_mem[ptr_q];
	assign op_take   = (st_q == S_IDLE) && op_valid && go;

	// result queue write: flush pending result on emit or at finish
	always_comb begin
		rq_push = 1'b0;
		rq_data = pend_q;
		if (go) begin
			if (st_q == S_FIN) begin
				rq_push = 1'b1;
				if (pend_v_q) begin
					rq_data.last = 1'b1;
				end else begin
					rq_data.kind         = tbea_pkg::KIND_NONE;
					rq_data.tag_out      = 8'd0;
					rq_data.queued_count = fill_q;
					rq_data.credit_now   = credit_q;
					rq_data.last         = 1'b1;
				end
			end else if ((st_q == S_DRAIN && !paused_q && !stopped_q && fill_q != '0
			             && afford && head_live)
			             || (st_q == S_STOP && fill_q != '0 && head_live)) begin
				rq_push = pend_v_q;
			end
		end
	end

	// queue memory write port
	always_comb begin
		mem_wr   = 1'b0;
		mem_addr = head_q;
		mem_live = 1'b0;
		if (go) begin
			case (st_q)
				S_IDLE: begin
					if (op_valid && op.op == tbea_pkg::CMD_SUBMIT && !stopped_q
					    && fill_q < tbea_pkg::FW'(tbea_pkg::QUEUE_DEPTH)
					    && !(!paused_q && afford)) begin
						mem_wr   = 1'b1;
						mem_addr = tail;
						mem_live = 1'b1;
					end
				end
				S_DRAIN: begin
					mem_wr = !paused_q && !stopped_q && fill_q != '0 && afford;
				end
				S_STOP: begin
					mem_wr = (fill_q != '0);
				end
				S_CANCEL: begin
					mem_addr = ptr_q;
					mem_wr   = (k_q != fill_q) && ptr_live && ptr_tag == id_q;
				end
				default: mem_wr = 1'b0;
			endcase
		end
	end

	// event queue memory
	always_ff @(posedge clk) begin
		if (mem_wr) begin
			live_mem[mem_addr] <= mem_live;
			if (mem_live) tag_mem[mem_addr] <= op.id;
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (rq_push) rq_q[rq_wr_q] <= rq_data;
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			credit_q  <= tbea_pkg::CREDIT_W'(tbea_pkg::USEC_PER_SEC);
			paused_q  <= 1'b0;
			stopped_q <= 1'b0;
			head_q    <= '0;
			fill_q    <= '0;
			ptr_q     <= '0;
			k_q       <= '0;
			id_q      <= '0;
			pend_v_q  <= 1'b0;
			pend_q    <= '0;
			rq_rd_q   <= 1'b0;
			rq_wr_q   <= 1'b0;
			rq_cnt_q  <= 2'd0;
		end else begin
			if (rq_push) rq_wr_q <= !rq_wr_q;
			if (pop && !empty) rq_rd_q <= !rq_rd_q;
			rq_cnt_q <= rq_cnt_q + {1'b0, rq_push} - {1'b0, pop && !empty};
			if (rate.done) credit_q <= rate.cap;
			if (go) begin
				case (st_q)
					S_IDLE: begin
						if (op_valid) begin
							st_q <= S_FIN;
							case (op.op)
								tbea_pkg::CMD_TICK: begin
									if (!stopped_q) begin
										if (sum > {3'b0, rate.cap}) credit_q <= rate.cap;
										else credit_q <= sum[tbea_pkg::CREDIT_W-1:0];
										st_q <= S_DRAIN;
									end
								end
								tbea_pkg::CMD_SUBMIT: begin
									pend_v_q            <= 1'b1;
									pend_q.tag_out      <= op.id;
									pend_q.last         <= 1'b0;
									pend_q.credit_now   <= credit_q;
									pend_q.queued_count <= fill_q;
									if (stopped_q) begin
										pend_q.kind <= tbea_pkg::KIND_STOPPED;
									end else if (fill_q >= tbea_pkg::FW'(tbea_pkg::QUEUE_DEPTH)) begin
										pend_q.kind <= tbea_pkg::KIND_FULL;
									end else if (!paused_q && afford) begin
										pend_q.kind       <= tbea_pkg::KIND_ADMIT;
										credit_q          <= credit_q - rate.cost;
										pend_q.credit_now <= credit_q - rate.cost;
									end else begin
										pend_q.kind         <= tbea_pkg::KIND_QUEUED;
										fill_q              <= fill_q + 1'b1;
										pend_q.queued_count <= fill_q + 1'b1;
									end
								end
								tbea_pkg::CMD_PAUSE: begin
									if (!stopped_q) paused_q <= 1'b1;
								end
								tbea_pkg::CMD_UNPAUSE: begin
									if (paused_q && !stopped_q) begin
										paused_q <= 1'b0;
										st_q     <= S_DRAIN;
									end
								end
								tbea_pkg::CMD_CLEAR: credit_q <= '0;
								tbea_pkg::CMD_CANCEL: begin
									id_q  <= op.id;
									ptr_q <= head_q;
									k_q   <= '0;
									st_q  <= S_CANCEL;
								end
								tbea_pkg::CMD_STOP: begin
									stopped_q <= 1'b1;
									st_q      <= S_STOP;
								end
								default: st_q <= S_FIN;
							endcase
						end
					end
					// pop head while credit lasts; cancelled entries cost nothing
					S_DRAIN: begin
						if (paused_q || stopped_q || fill_q == '0 || !afford) begin
							st_q <= S_FIN;
						end else begin
							head_q <= head_q + 1'b1;
							fill_q <= fill_q - 1'b1;
							if (head_live) begin
								credit_q            <= credit_q - rate.cost;
								pend_v_q            <= 1'b1;
								pend_q.kind         <= tbea_pkg::KIND_ADMIT;
								pend_q.tag_out      <= head_tag;
								pend_q.queued_count <= fill_q - 1'b1;
								pend_q.credit_now   <= credit_q - rate.cost;
								pend_q.last         <= 1'b0;
							end
						end
					end
					// flush all live entries as admitted
					S_STOP: begin
						if (fill_q == '0) begin
							st_q <= S_FIN;
						end else begin
							head_q <= head_q + 1'b1;
							fill_q <= fill_q - 1'b1;
							if (head_live) begin
								pend_v_q            <= 1'b1;
								pend_q.kind         <= tbea_pkg::KIND_ADMIT;
								pend_q.tag_out      <= head_tag;
								pend_q.queued_count <= fill_q - 1'b1;
								pend_q.credit_now   <= credit_q;
								pend_q.last         <= 1'b0;
							end
						end
					end
					// find oldest live entry with the tag and mark it dead
					S_CANCEL: begin
						if (k_q == fill_q || (ptr_live && ptr_tag == id_q)) begin
							st_q <= S_FIN;
						end else begin
							k_q   <= k_q + 1'b1;
							ptr_q <= ptr_q + 1'b1;
						end
					end
					S_FIN: begin
						pend_v_q <= 1'b0;
						st_q     <= S_IDLE;
					end
					default: st_q <= S_IDLE;
				endcase
			end
		end
	end

	assign empty    = (rq_cnt_q == 2'd0);
	assign res_item = rq_q[rq_rd_q];

`ifndef ASSERT_OFF
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= tbea_pkg::FW'(tbea_pkg::QUEUE_DEPTH)) else $error("queue overfill");
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_IDLE |-> !pend_v_q) else $error("pending result left over");
	a_cancel_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_CANCEL |-> k_q <= fill_q) else $error("cancel walk past fill");
	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> stopped_q) else $error("stop flag cleared");
	a_credit_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_IDLE && !rate.busy) |-> credit_q <= rate.cap)
		else $error("credit above cap");
`endif

endmodule

### design/token_bucket_event_admitter_core.sv
// ----------------------------------------------------------------------------
// token_bucket_event_admitter_core: token-bucket admitter for tagged events
// Front part queues commands, back part runs them against credit and the
// event queue, rate unit derives unit cost and cap from the registers.
//
//  channel   direction  handshake             payload
//  command   in         push / full           in_item  (cmd, event_id, elapsed_us)
//  result    out        pop / empty           res_item (kind, tag, count, credit, last)
//  config    in         psel/penable/pready   paddr, pwdata, prdata
//
// An accepted item is registered in the front queue before the back takes it.
// Submit, pause, clear and no-op go from idle straight to the finish step; tick,
// unpause, stop and cancel may first walk the queue, up to 16 entries, with the
// back sequencer stepping one entry a cycle while the back part is not stalled.
// A register write starts a divide and multiply; commands wait for it.
// Reset restores rate 1, burst 1 and credit 1000000 us with an empty queue.
// A full result queue stalls the back part; the front takes items until its
// two slots are full.
// ----------------------------------------------------------------------------
module token_bucket_event_admitter_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  tbea_pkg::in_t  in_item,
	output logic           empty,
	input  logic           pop,
	output tbea_pkg::out_t res_item,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);

	logic            op_valid;
	logic            op_take;
	tbea_pkg::op_t   op;
	tbea_pkg::rate_t rate;
	logic [15:0]     eps;
	logic [15:0]     burst;
	logic            wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// register readback
	always_comb begin
		if (paddr[2] == 1'(tbea_pkg::ADDR_BURST)) prdata = {16'd0, burst};
		else prdata = {16'd0, eps};
	end

	tbea_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_item  (in_item),
		.op_valid (op_valid),
		.op       (op),
		.op_take  (op_take)
	);

	tbea_rate u_rate (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_idx  (paddr[2]),
		.wr_data (pwdata[15:0]),
		.eps     (eps),
		.burst   (burst),
		.rate    (rate)
	);

	tbea_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op       (op),
		.op_take  (op_take),
		.rate     (rate),
		.empty    (empty),
		.pop      (pop),
		.res_item (res_item)
	);

endmodule
